### rtl/box_exit_crossing_assert.svh
// Assertion macros used by the box exit crossing checker.
`ifndef BOX_EXIT_CROSSING_ASSERT_SVH
`define BOX_EXIT_CROSSING_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define BEC_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("box_exit_crossing assertion failed");

// Next-cycle implication, masked during reset.
`define BEC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("box_exit_crossing assertion failed");

// Next-cycle implication that also holds across reset.
`define BEC_ASSERT_NEXT_ANY(label, clk, a, b) \
    label: assert property (@(posedge clk) (a) |=> (b)) \
        else $error("box_exit_crossing assertion failed");

`endif

### rtl/bec_pkg.sv
// Package for the box exit crossing block: defaults, side codes, register indexes.
package bec_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    // Q format fraction bits; only the reset value of the box edges depends on it
    localparam int FRAC_BITS = 16;

    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_TOP    = 2'd3
    } t_side;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_RIGHT  = 2'd1;
    localparam logic [1:0] CFG_BOTTOM = 2'd2;
    localparam logic [1:0] CFG_TOP    = 2'd3;

    // Width of a packed job word: 8 flag/side bits, 5 coordinates, 4 magnitudes
    function automatic int bec_job_w(int cw);
        return 9 * cw + 12;
    endfunction

endpackage

### rtl/box_exit_crossing.sv
// Top level of the box exit crossing block: box registers, front, queue, back.
//
// Usage: an input beat carries one segment (start and end point, signed
// fixed point). Each accepted beat yields exactly one output beat with the
// exit side, the exit point and the bad segment flag, in input order.
// Box edges are written through the plain write port (i_cfg_we, index,
// data) while the block is idle; they reset to the unit square.
// Throughput: one segment per cycle while the receiver does not stall.
// The two parallel pipelined dividers, one quotient bit per stage, follow
// the product stage.
// A front register and a two-entry queue separate the input side from the
// divider pipeline; when the receiver stalls the pipeline holds, the queue
// fills, and o_ready of the input side drops once the front register is full too.
// Reset clears all valid state and restores the box edges; no beat is
// shown until a new one is accepted.
module box_exit_crossing import bec_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_exit_side,
    output logic signed [COORD_WIDTH-1:0] o_cross_x,
    output logic signed [COORD_WIDTH-1:0] o_cross_y,
    output logic                          o_bad_segment,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data
);
    localparam int CW = COORD_WIDTH;
    localparam int JW = bec_job_w(COORD_WIDTH);
    localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;

    logic signed [CW-1:0] r_box_left, r_box_right, r_box_bottom, r_box_top;
    logic          f_vld, f_rdy, q_vld, q_rdy;
    logic [JW-1:0] f_job, q_job;

    // Box edge registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= '0;
            r_box_right  <= ONE;
            r_box_bottom <= '0;
            r_box_top    <= ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT:   r_box_left   <= i_cfg_data;
                CFG_RIGHT:  r_box_right  <= i_cfg_data;
                CFG_BOTTOM: r_box_bottom <= i_cfg_data;
                CFG_TOP:    r_box_top    <= i_cfg_data;
                default:    r_box_top    <= r_box_top;
            endcase
        end
    end

    bec_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_box_left   (r_box_left),
        .i_box_right  (r_box_right),
        .i_box_bottom (r_box_bottom),
        .i_box_top    (r_box_top),
        .o_job_valid  (f_vld),
        .i_job_ready  (f_rdy),
        .o_job        (f_job)
    );

    bec_queue #(.W(JW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_vld),
        .o_ready (f_rdy),
        .i_data  (f_job),
        .o_valid (q_vld),
        .i_ready (q_rdy),
        .o_data  (q_job)
    );

    bec_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_vld),
        .o_job_ready   (q_rdy),
        .i_job         (q_job),
        .i_box_bottom  (r_box_bottom),
        .i_box_top     (r_box_top),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_exit_side   (o_exit_side),
        .o_cross_x     (o_cross_x),
        .o_cross_y     (o_cross_y),
        .o_bad_segment (o_bad_segment)
    );

endmodule

### rtl/bec_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient clamped.
module bec_div import bec_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [2*COORD_WIDTH+1:0]     i_num,
    input  logic [COORD_WIDTH:0]         i_den,
    output logic [COORD_WIDTH+2:0]       o_quo
);
    localparam int CW = COORD_WIDTH;
    localparam int V  = CW + 1;
    localparam int NQ = CW + 3;
    localparam int PW = 2 * V;
    localparam logic [NQ-1:0] LIM = {1'b1, {(NQ-1){1'b0}}};

    logic [V-1:0]  r_rem [0:NQ];
    logic [NQ-1:0] r_q   [0:NQ];
    logic [NQ-1:0] r_low [0:NQ];
    logic [V-1:0]  r_den [0:NQ];
    logic          r_ovf [0:NQ];

    // Entry stage: bits above the quotient range decide overflow
    logic [V-1:0] n_top;
    logic         n_ovf;
    assign n_top = {2'b00, i_num[PW-1:NQ]};
    assign n_ovf = (n_top >= i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_ovf ? '0 : n_top;
            r_q[0]   <= '0;
            r_low[0] <= i_num[NQ-1:0];
            r_den[0] <= i_den;
            r_ovf[0] <= n_ovf;
        end
    end

    // One shift/compare/subtract per stage
    for (genvar k = 1; k <= NQ; k++) begin : g_stage
        logic [V:0]   n_t;
        logic         n_ge;
        logic [V:0]   n_diff;
        assign n_t    = {r_rem[k-1], r_low[k-1][NQ-1]};
        assign n_ge   = (n_t >= {1'b0, r_den[k-1]});
        assign n_diff = n_t - {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_diff[V-1:0] : n_t[V-1:0];
                r_q[k]   <= {r_q[k-1][NQ-2:0], n_ge};
                r_low[k] <= {r_low[k-1][NQ-2:0], 1'b0};
                r_den[k] <= r_den[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_quo = (r_ovf[NQ] || (r_q[NQ] > LIM)) ? LIM : r_q[NQ];

endmodule

### rtl/bec_front.sv
// Front end: accepts segments, classifies them and prepares magnitudes.
module bec_front import bec_pkg::*; #(
    parameter  int COORD_WIDTH = DEF_COORD_WIDTH,
    localparam int JW = bec_job_w(COORD_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_box_left,
    input  logic signed [COORD_WIDTH-1:0] i_box_right,
    input  logic signed [COORD_WIDTH-1:0] i_box_bottom,
    input  logic signed [COORD_WIDTH-1:0] i_box_top,
    output logic                          o_job_valid,
    input  logic                          i_job_ready,
    output logic [JW-1:0]                 o_job
);
    localparam int CW = COORD_WIDTH;
    localparam int V  = CW + 1;

    // Keep identical to the layout in bec_back
    typedef struct packed {
        logic          direct;
        logic          bad;
        logic [1:0]    side;
        logic          up;
        logic          right;
        logic          run_neg;
        logic          rise_neg;
        logic [CW-1:0] dcx;
        logic [CW-1:0] dcy;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex_edge;
        logic [V-1:0]  adx;
        logic [V-1:0]  ady;
        logic [V-1:0]  run_mag;
        logic [V-1:0]  rise_mag;
    } t_job;

    logic  r_vld;
    t_job  r_job;
    t_job  n_job;

    logic signed [V-1:0] sx_e, sy_e, ex_e, ey_e;
    logic signed [V-1:0] dx, dy, run, rise;

    assign sx_e = {i_start_x[CW-1], i_start_x};
    assign sy_e = {i_start_y[CW-1], i_start_y};
    assign ex_e = {i_end_x[CW-1], i_end_x};
    assign ey_e = {i_end_y[CW-1], i_end_y};
    assign dx   = ex_e - sx_e;
    assign dy   = ey_e - sy_e;

    // Classify and build the job word
    always_comb begin
        n_job          = '0;
        n_job.sx       = i_start_x;
        n_job.sy       = i_start_y;
        n_job.up       = ~dy[V-1];
        n_job.right    = ~dx[V-1];
        n_job.adx      = dx[V-1] ? V'(-dx) : V'(dx);
        n_job.ady      = dy[V-1] ? V'(-dy) : V'(dy);
        n_job.ex_edge  = dx[V-1] ? i_box_left : i_box_right;
        run  = dx[V-1] ? (sx_e - {i_box_left[CW-1], i_box_left})
                       : ({i_box_right[CW-1], i_box_right} - sx_e);
        rise = dy[V-1] ? (sy_e - {i_box_bottom[CW-1], i_box_bottom})
                       : ({i_box_top[CW-1], i_box_top} - sy_e);
        n_job.run_neg  = run[V-1];
        n_job.rise_neg = rise[V-1];
        n_job.run_mag  = run[V-1] ? V'(-run) : V'(run);
        n_job.rise_mag = rise[V-1] ? V'(-rise) : V'(rise);
        if (dx == '0) begin
            n_job.direct = 1'b1;
            if (i_end_y >= i_box_top) begin
                n_job.side = SIDE_TOP;
                n_job.dcx  = i_start_x;
                n_job.dcy  = i_box_top;
            end else if (i_end_y <= i_box_bottom) begin
                n_job.side = SIDE_BOTTOM;
                n_job.dcx  = i_start_x;
                n_job.dcy  = i_box_bottom;
            end else begin
                n_job.bad  = 1'b1;
            end
        end else if (dy == '0) begin
            n_job.direct = 1'b1;
            if (i_end_x >= i_box_right) begin
                n_job.side = SIDE_RIGHT;
                n_job.dcx  = i_box_right;
                n_job.dcy  = i_start_y;
            end else if (i_end_x <= i_box_left) begin
                n_job.side = SIDE_LEFT;
                n_job.dcx  = i_box_left;
                n_job.dcy  = i_start_y;
            end else begin
                n_job.bad  = 1'b1;
            end
        end
    end

    assign o_ready = ~r_vld | i_job_ready;

    // Output register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_vld;
    assign o_job       = r_job;

endmodule

### rtl/bec_queue.sv
// Two-entry queue between front and back ends.
module bec_queue import bec_pkg::*; #(
    parameter int W = bec_job_w(DEF_COORD_WIDTH)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [0:1];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid & o_ready;
    assign pop     = o_valid & i_ready;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### rtl/bec_back.sv
// Back end: products, two parallel dividers, edge choice and saturation.
module bec_back import bec_pkg::*; #(
    parameter  int COORD_WIDTH = DEF_COORD_WIDTH,
    localparam int JW = bec_job_w(COORD_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  logic [JW-1:0]                 i_job,
    input  logic signed [COORD_WIDTH-1:0] i_box_bottom,
    input  logic signed [COORD_WIDTH-1:0] i_box_top,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_exit_side,
    output logic signed [COORD_WIDTH-1:0] o_cross_x,
    output logic signed [COORD_WIDTH-1:0] o_cross_y,
    output logic                          o_bad_segment
);
    localparam int CW = COORD_WIDTH;
    localparam int V  = CW + 1;
    localparam int NQ = CW + 3;
    localparam int WA = CW + 4;
    localparam int ND = NQ + 2;

    // Keep identical to the layout in bec_front
    typedef struct packed {
        logic          direct;
        logic          bad;
        logic [1:0]    side;
        logic          up;
        logic          right;
        logic          run_neg;
        logic          rise_neg;
        logic [CW-1:0] dcx;
        logic [CW-1:0] dcy;
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] ex_edge;
        logic [V-1:0]  adx;
        logic [V-1:0]  ady;
        logic [V-1:0]  run_mag;
        logic [V-1:0]  rise_mag;
    } t_job;

    function automatic logic [CW-1:0] sat(logic signed [WA-1:0] v);
        logic fits;
        fits = (v[WA-1:CW-1] == {(WA-CW+1){v[CW-1]}});
        if (fits)          return v[CW-1:0];
        else if (v[WA-1])  return {1'b1, {(CW-1){1'b0}}};
        else               return {1'b0, {(CW-1){1'b1}}};
    endfunction

    logic en;
    t_job job_in;
    t_job r_job [0:ND];
    logic r_vld [0:ND];
    logic [2*V-1:0] r_pa, r_pb;
    logic [NQ-1:0]  qa, qb;
    logic signed [WA-1:0] r_y2, r_x2;
    logic signed [WA-1:0] n_y2, n_x2;
    t_job ja, jo;

    logic         r_out_vld;
    logic [1:0]   r_side;
    logic [CW-1:0] r_cx, r_cy;
    logic         r_bad;
    logic [1:0]   n_side;
    logic [CW-1:0] n_cx, n_cy;
    logic         hit_x;
    logic signed [WA-1:0] top_e, bot_e;

    // Whole pipeline moves when the output register is free or being taken
    assign en          = ~r_out_vld | i_ready;
    assign o_job_ready = en;
    assign job_in      = i_job;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job[0] <= job_in;
            r_pa     <= job_in.ady * job_in.run_mag;
            r_pb     <= job_in.adx * job_in.rise_mag;
        end
    end

    // Sideband delay alongside the dividers
    for (genvar k = 1; k <= ND; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (en) r_job[k] <= r_job[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ND; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_job_valid;
            for (int k = 1; k <= ND; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    bec_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_pa),
        .i_den (r_job[0].adx),
        .o_quo (qa)
    );

    bec_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_pb),
        .i_den (r_job[0].ady),
        .o_quo (qb)
    );

    // Offset stage: candidate exit ordinate and abscissa
    assign ja = r_job[ND-1];
    always_comb begin
        logic signed [WA-1:0] qa_s, qb_s, sy_s, sx_s;
        qa_s = $signed({1'b0, qa});
        qb_s = $signed({1'b0, qb});
        sy_s = {{(WA-CW){ja.sy[CW-1]}}, ja.sy};
        sx_s = {{(WA-CW){ja.sx[CW-1]}}, ja.sx};
        n_y2 = ((~ja.up) != ja.run_neg) ? (sy_s - qa_s) : (sy_s + qa_s);
        n_x2 = ((~ja.right) != ja.rise_neg) ? (sx_s - qb_s) : (sx_s + qb_s);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y2 <= n_y2;
            r_x2 <= n_x2;
        end
    end

    // Edge choice and saturation
    assign jo    = r_job[ND];
    assign top_e = {{(WA-CW){i_box_top[CW-1]}}, i_box_top};
    assign bot_e = {{(WA-CW){i_box_bottom[CW-1]}}, i_box_bottom};
    assign hit_x = jo.up ? (r_y2 < top_e) : (r_y2 > bot_e);

    always_comb begin
        if (jo.direct) begin
            n_side = jo.side;
            n_cx   = jo.dcx;
            n_cy   = jo.dcy;
        end else if (hit_x) begin
            n_side = jo.right ? SIDE_RIGHT : SIDE_LEFT;
            n_cx   = jo.ex_edge;
            n_cy   = sat(r_y2);
        end else begin
            n_side = jo.up ? SIDE_TOP : SIDE_BOTTOM;
            n_cx   = sat(r_x2);
            n_cy   = jo.up ? i_box_top : i_box_bottom;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[ND];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side <= n_side;
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_bad  <= jo.bad;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_exit_side   = r_side;
    assign o_cross_x     = r_cx;
    assign o_cross_y     = r_cy;
    assign o_bad_segment = r_bad;

endmodule

### rtl/bec_checker.sv
// Port-level checker for the box exit crossing block, bound to the top level.
`include "box_exit_crossing_assert.svh"
module bec_checker import bec_pkg::*; #(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [1:0]                    o_exit_side,
    input logic signed [COORD_WIDTH-1:0] o_cross_x,
    input logic signed [COORD_WIDTH-1:0] o_cross_y,
    input logic                          o_bad_segment
);
    // A stalled result beat stays up
    `BEC_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // and keeps its exit point
    `BEC_ASSERT_NEXT(a_hold_point, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_cross_x) && $stable(o_cross_y))
    // A bad segment reports zero side and point
    `BEC_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_segment, o_exit_side == SIDE_LEFT && o_cross_x == '0 && o_cross_y == '0)
    // Nothing is shown right after reset
    `BEC_ASSERT_NEXT_ANY(a_reset_idle, i_clk, !i_rst_n, !o_valid)
endmodule

bind box_exit_crossing bec_checker #(.COORD_WIDTH(COORD_WIDTH)) u_bec_checker (.*);
